FILE: rtl/core/odbp_pkg.sv
`default_nettype none

package odbp_pkg;

   // Channel sum of one pixel, 0 to 765.
   localparam int unsigned SUM_W = 10;
   localparam int unsigned ROW_BYTES_W = 10;

   localparam int unsigned DITHER_LEVELS = 18;
   localparam int unsigned DITHER_DIVISOR = 'h300 / DITHER_LEVELS;
   localparam logic [7:0] LEFT_PIXEL_MASK = 8'h80;

   localparam logic [1:0] PHASE_LAST = 2'd2;

   typedef logic [4:0] threshold_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             band_start;
   } odbp_pix_type;

   // A pixel gets ink when 17 - sum/42 >= threshold, which is the same as
   // sum < 42 * (18 - threshold). The bound is returned directly.
   function automatic logic [SUM_W-1:0] ink_bound(input logic [1:0] row_phase,
                                                  input logic [1:0] col_phase);
      threshold_type thr;
      thr = 5'd1;
      case ({row_phase, col_phase})
         4'b00_00: thr = 5'd1;
         4'b00_01: thr = 5'd11;
         4'b00_10: thr = 5'd7;
         4'b01_00: thr = 5'd13;
         4'b01_01: thr = 5'd3;
         4'b01_10: thr = 5'd17;
         4'b10_00: thr = 5'd9;
         4'b10_01: thr = 5'd15;
         4'b10_10: thr = 5'd5;
         default:  thr = 5'd1;
      endcase
      return SUM_W'(DITHER_DIVISOR * (DITHER_LEVELS - 32'(thr)));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/odbp_req_if.sv
`default_nettype none

interface odbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       band_start;

   modport source (output valid, output red, output green, output blue,
                   output band_start, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input band_start, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/odbp_rsp_if.sv
`default_nettype none

interface odbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       row_end;

   modport source (output valid, output packed_byte, output row_end, input ready);
   modport sink   (input valid, input packed_byte, input row_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ordered_dither_bit_packer.sv
// Ordered-dither monochrome bit packer.
//
// Pixels arrive on req_if, one RGB pixel per word, in raster order. Each
// pixel is thresholded against a fixed 3x3 ordered-dither matrix and becomes
// one bit (1 = ink). Eight pixels make one byte on rsp_if, leftmost pixel in
// bit 7, and the last byte of each raster row carries row_end. A word with
// band_start set is taken as row 0, column 0 of a new band; any partly built
// byte is dropped.
// The row length in bytes is written through csr_write_enable and
// csr_write_data; the user must do so only while the block is idle, which
// the block does not enforce. Zero acts as one and values above MAX_ROW_BYTES
// act as MAX_ROW_BYTES. After reset it is one byte. A pixel is accepted
// every clock unless the output stalls. The word that completes a byte
// passes through two registers: the channel-sum register, written on
// acceptance, and the output register, written by the packing stage when
// it takes the word. When the receiver stalls, the output byte holds and one
// further pixel may be taken into the sum register before req_if.ready falls.
// Reset empties both stages and clears the column, phase and byte state.
`default_nettype none

module ordered_dither_bit_packer import odbp_pkg::*; #(
   parameter int unsigned MAX_ROW_BYTES = 512
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [ROW_BYTES_W-1:0] csr_write_data,
   odbp_req_if.sink                    req_if,
   odbp_rsp_if.source                  rsp_if
);

   // The column counter must hold the full row length in pixels.
   localparam int unsigned BCOL_W = $clog2(MAX_ROW_BYTES * 8) + 1;
   localparam int unsigned CMP_W  = (BCOL_W > ROW_BYTES_W) ? BCOL_W : ROW_BYTES_W;

   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic [CMP_W-1:0]       rb_wide, eff_bytes;
   logic [BCOL_W-1:0]      row_limit;
   logic                   pix_valid, advance;
   odbp_pix_type           pix;

   assign row_bytes_in = csr_write_enable ? csr_write_data : row_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_W'(1);
      end else begin
         row_bytes_ff <= row_bytes_in;
      end
   end

   // Clamp the row length into its legal range and turn it into pixels.
   always_comb begin
      rb_wide = CMP_W'(row_bytes_ff);
      if (rb_wide == '0) begin
         eff_bytes = CMP_W'(1);
      end else if (rb_wide > CMP_W'(MAX_ROW_BYTES)) begin
         eff_bytes = CMP_W'(MAX_ROW_BYTES);
      end else begin
         eff_bytes = rb_wide;
      end
      row_limit = {eff_bytes[BCOL_W-4:0], 3'b000};
   end

   odbp_sum_stage u_sum_stage (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .advance   (advance),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   odbp_packer #(
      .BCOL_W (BCOL_W)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix       (pix),
      .row_limit (row_limit),
      .advance   (advance),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

FILE: rtl/core/odbp_sum_stage.sv
`default_nettype none

module odbp_sum_stage import odbp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   odbp_req_if.sink    req_if,
   input  wire logic   advance,
   output logic        pix_valid,
   output odbp_pix_type pix
);

   logic         valid_ff, valid_in;
   odbp_pix_type pix_ff, pix_in;
   logic         accept;

   // The stage frees itself in the same cycle that the packer takes its word.
   assign req_if.ready = !valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      pix_in   = pix_ff;
      if (accept) begin
         valid_in          = 1'b1;
         pix_in.sum        = SUM_W'(req_if.red) + SUM_W'(req_if.green)
                           + SUM_W'(req_if.blue);
         pix_in.band_start = req_if.band_start;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pix_ff <= pix_in;
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

endmodule

`default_nettype wire

FILE: rtl/core/odbp_packer.sv
`default_nettype none

module odbp_packer import odbp_pkg::*; #(
   parameter int unsigned BCOL_W = 13
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pix_valid,
   input  wire odbp_pix_type      pix,
   input  wire logic [BCOL_W-1:0] row_limit,
   output logic                   advance,
   odbp_rsp_if.source             rsp_if
);

   logic [BCOL_W-1:0] bit_column_ff, bit_column_in;
   logic [1:0]        column_phase_ff, column_phase_in;
   logic [1:0]        row_phase_ff, row_phase_in;
   logic [7:0]        byte_acc_ff, byte_acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        packed_byte_ff, packed_byte_in;
   logic              row_end_ff, row_end_in;

   logic [BCOL_W-1:0] col_cur, col_inc;
   logic [1:0]        cph_cur, rph_cur, cph_inc;
   logic [7:0]        acc_cur, acc_new;
   logic              ink, byte_done, row_done;

   assign advance = pix_valid && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      col_cur = pix.band_start ? '0    : bit_column_ff;
      cph_cur = pix.band_start ? 2'd0  : column_phase_ff;
      rph_cur = pix.band_start ? 2'd0  : row_phase_ff;
      acc_cur = pix.band_start ? 8'h00 : byte_acc_ff;

      ink     = pix.sum < ink_bound(rph_cur, cph_cur);
      acc_new = ink ? (acc_cur | (LEFT_PIXEL_MASK >> col_cur[2:0])) : acc_cur;

      col_inc   = col_cur + BCOL_W'(1);
      cph_inc   = (cph_cur == PHASE_LAST) ? 2'd0 : cph_cur + 2'd1;
      byte_done = (col_inc[2:0] == 3'd0);
      row_done  = (col_inc >= row_limit);

      bit_column_in   = bit_column_ff;
      column_phase_in = column_phase_ff;
      row_phase_in    = row_phase_ff;
      byte_acc_in     = byte_acc_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      packed_byte_in  = packed_byte_ff;
      row_end_in      = row_end_ff;

      if (advance) begin
         bit_column_in   = col_inc;
         column_phase_in = cph_inc;
         row_phase_in    = rph_cur;
         byte_acc_in     = acc_new;
         if (byte_done) begin
            rsp_valid_in   = 1'b1;
            packed_byte_in = acc_new;
            row_end_in     = row_done;
            byte_acc_in    = 8'h00;
            if (row_done) begin
               bit_column_in   = '0;
               column_phase_in = 2'd0;
               row_phase_in    = (rph_cur == PHASE_LAST) ? 2'd0 : rph_cur + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_column_ff   <= '0;
         column_phase_ff <= 2'd0;
         row_phase_ff    <= 2'd0;
         byte_acc_ff     <= 8'h00;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bit_column_ff   <= bit_column_in;
         column_phase_ff <= column_phase_in;
         row_phase_ff    <= row_phase_in;
         byte_acc_ff     <= byte_acc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      packed_byte_ff <= packed_byte_in;
      row_end_ff     <= row_end_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.packed_byte = packed_byte_ff;
   assign rsp_if.row_end     = row_end_ff;

endmodule

`default_nettype wire

FILE: rtl/core/odbp_checker.sv
`default_nettype none

module odbp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] packed_byte,
   input wire logic       row_end
);

   logic req_accept, rsp_stall;

   assign req_accept = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;

   // Both stages are empty straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("odbp: pipeline not empty after reset");

   // A stalled byte keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_valid && $stable(packed_byte) && $stable(row_end))
      else $error("odbp: stalled byte changed");

   // One word taken during a stall fills the sum stage; a longer stall
   // must then close the input.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_stall) ##1 rsp_stall |-> !req_ready)
      else $error("odbp: input open with both stages full");

   // With the output free, the input is never closed.
   a_no_needless_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("odbp: input closed while output is empty");

endmodule

bind ordered_dither_bit_packer odbp_checker u_odbp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .packed_byte (rsp_if.packed_byte),
   .row_end     (rsp_if.row_end)
);

`default_nettype wire
